>>> rtl/point_dedup_by_tolerance_macros.svh
// Assertion helpers used by point_dedup_by_tolerance. Clocked on i_clk, off while i_rst_n is low.
`ifndef POINT_DEDUP_BY_TOLERANCE_MACROS_SVH
`define POINT_DEDUP_BY_TOLERANCE_MACROS_SVH

// Same-cycle implication.
`define PDT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PDT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pdt_pkg.sv
package pdt_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 20;
    localparam int LANES      = 8;
    localparam int ROWS       = MAX_POINTS / LANES;
    localparam int ROW_BITS   = $clog2(ROWS);
    localparam int LANE_BITS  = $clog2(LANES);
    localparam int IDX_BITS   = ROW_BITS + LANE_BITS;
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int NROW_BITS  = $clog2(ROWS + 1);
    localparam int SLOT_BITS  = 10;
    localparam int TOL_BITS   = 42;
    localparam int ENTRY_BITS = 3 * COORD_BITS;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    // |a - b|; the difference fits one extra bit, and so does its magnitude.
    function automatic logic [DIFF_BITS-1:0] abs_diff(input t_coord a, input t_coord b);
        logic signed [DIFF_BITS-1:0] d;
        d = DIFF_BITS'(a) - DIFF_BITS'(b);
        return d[DIFF_BITS-1] ? $unsigned(-d) : $unsigned(d);
    endfunction

endpackage

>>> rtl/pdt_point_if.sv
interface pdt_point_if;
    logic            valid;
    logic            ready;
    pdt_pkg::t_coord coord_x;
    pdt_pkg::t_coord coord_y;
    pdt_pkg::t_coord coord_z;
    logic            new_set;

    modport source(output valid, coord_x, coord_y, coord_z, new_set, input ready);
    modport sink(input valid, coord_x, coord_y, coord_z, new_set, output ready);
endinterface

>>> rtl/pdt_result_if.sv
interface pdt_result_if;
    logic                          valid;
    logic                          ready;
    logic                          distinct;
    logic                          overflow;
    logic [pdt_pkg::SLOT_BITS-1:0] slot;

    modport source(output valid, distinct, overflow, slot, input ready);
    modport sink(input valid, distinct, overflow, slot, output ready);
endinterface

>>> rtl/pdt_cfg_if.sv
interface pdt_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [pdt_pkg::TOL_BITS-1:0] tolerance_squared;

    modport source(output valid, tolerance_squared, input ready);
    modport sink(input valid, tolerance_squared, output ready);
endinterface

>>> rtl/point_dedup_by_tolerance.sv
// Greedy point deduplication. Kept points live in eight single-port-read RAM banks
// (entry i in bank i mod 8, row i/8), so one row of eight points is read per cycle and
// checked by eight compare lanes. One point is handled at a time: after acceptance the
// block scans ceil(count/8) rows, where count is the number of kept points, then decides
// and, for a distinct point while the table of 1024 points has room, stores it. The
// result sits in an output register, so the next point can be accepted while it waits.
// A new_set point empties the table first. Tolerance writes are taken at any time but
// belong between points.
module point_dedup_by_tolerance (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pdt_point_if.sink    i_point,
    pdt_result_if.source o_result,
    pdt_cfg_if.sink      i_cfg
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state                           r_state;
    logic [pdt_pkg::TOL_BITS-1:0]     r_tol;
    logic [pdt_pkg::CNT_BITS-1:0]     r_count;
    pdt_pkg::t_point                  r_pt;
    logic [pdt_pkg::NROW_BITS-1:0]    r_rd_row;
    logic [pdt_pkg::NROW_BITS-1:0]    r_chk_row;
    logic                             r_found;
    logic [pdt_pkg::IDX_BITS-1:0]     r_match;
    logic                             r_iss_vld;
    logic [pdt_pkg::LANES-1:0]        r_lane_en;
    logic                             r_out_valid;
    logic                             r_out_distinct;
    logic                             r_out_overflow;
    logic [pdt_pkg::SLOT_BITS-1:0]    r_out_slot;

    logic [pdt_pkg::NROW_BITS-1:0]    w_nrows;
    logic                             w_issue;
    logic [pdt_pkg::LANES-1:0]        w_lane_en;
    logic                             w_out_free;
    logic                             w_full;
    logic                             w_store;
    logic [pdt_pkg::LANES-1:0]        w_vld;
    logic [pdt_pkg::LANES-1:0]        w_hit;
    logic                             w_any;
    logic [pdt_pkg::LANE_BITS-1:0]    w_hit_lane;
    pdt_pkg::t_point                  w_rdata [pdt_pkg::LANES];
    logic                             w_accept;
    logic [pdt_pkg::CNT_BITS-1:0]     n_count_p1;

    assign w_accept   = i_point.valid && i_point.ready;
    assign w_nrows    = pdt_pkg::NROW_BITS'(
        (r_count + pdt_pkg::CNT_BITS'(pdt_pkg::LANES - 1)) >> pdt_pkg::LANE_BITS);
    assign w_issue    = (r_state == S_SCAN) && (r_rd_row < w_nrows);
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_full     = (r_count >= pdt_pkg::CNT_BITS'(pdt_pkg::MAX_POINTS));
    assign w_store    = (r_state == S_DONE) && w_out_free && !r_found && !w_full;
    assign n_count_p1 = r_count + pdt_pkg::CNT_BITS'(1);

    always_comb begin
        for (int l = 0; l < pdt_pkg::LANES; l++) begin
            w_lane_en[l] = pdt_pkg::CNT_BITS'({r_rd_row[pdt_pkg::ROW_BITS-1:0],
                                               pdt_pkg::LANE_BITS'(l)}) < r_count;
        end
    end

    // lowest matching lane within the row
    always_comb begin
        w_any      = |w_hit;
        w_hit_lane = '0;
        for (int l = pdt_pkg::LANES - 1; l >= 0; l--) begin
            if (w_hit[l]) begin
                w_hit_lane = pdt_pkg::LANE_BITS'(l);
            end
        end
    end

    for (genvar l = 0; l < pdt_pkg::LANES; l++) begin : g_lane
        pdt_ram #(
            .WIDTH(pdt_pkg::ENTRY_BITS),
            .DEPTH(pdt_pkg::ROWS)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_store && (r_count[pdt_pkg::LANE_BITS-1:0] == pdt_pkg::LANE_BITS'(l))),
            .i_waddr(r_count[pdt_pkg::IDX_BITS-1:pdt_pkg::LANE_BITS]),
            .i_wdata(r_pt),
            .i_raddr(r_rd_row[pdt_pkg::ROW_BITS-1:0]),
            .o_rdata(w_rdata[l])
        );

        pdt_lane u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (r_iss_vld),
            .i_en   (r_lane_en[l]),
            .i_pt   (r_pt),
            .i_entry(w_rdata[l]),
            .i_tol  (r_tol),
            .o_vld  (w_vld[l]),
            .o_hit  (w_hit[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tol       <= '0;
            r_count     <= '0;
            r_rd_row    <= '0;
            r_chk_row   <= '0;
            r_found     <= 1'b0;
            r_iss_vld   <= 1'b0;
            r_lane_en   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_tol <= i_cfg.tolerance_squared;
            end
            r_iss_vld <= w_issue;
            r_lane_en <= w_lane_en;
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pt      <= '{x: i_point.coord_x, y: i_point.coord_y,
                                       z: i_point.coord_z};
                        r_rd_row  <= '0;
                        r_chk_row <= '0;
                        r_found   <= 1'b0;
                        if (i_point.new_set) begin
                            r_count <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_issue) begin
                        r_rd_row <= r_rd_row + pdt_pkg::NROW_BITS'(1);
                    end
                    if (w_vld[0]) begin
                        r_chk_row <= r_chk_row + pdt_pkg::NROW_BITS'(1);
                        if (!r_found && w_any) begin
                            r_found <= 1'b1;
                            r_match <= {r_chk_row[pdt_pkg::ROW_BITS-1:0], w_hit_lane};
                        end
                    end
                    // every issued row has come back through the lanes
                    if (r_chk_row == w_nrows) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_found) begin
                            r_out_distinct <= 1'b0;
                            r_out_overflow <= 1'b0;
                            r_out_slot     <= r_match[pdt_pkg::SLOT_BITS-1:0];
                        end else if (w_full) begin
                            r_out_distinct <= 1'b1;
                            r_out_overflow <= 1'b1;
                            r_out_slot     <= '0;
                        end else begin
                            r_out_distinct <= 1'b1;
                            r_out_overflow <= 1'b0;
                            r_out_slot     <= r_count[pdt_pkg::SLOT_BITS-1:0];
                            r_count        <= n_count_p1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_point.ready     = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_result.valid    = r_out_valid;
    assign o_result.distinct = r_out_distinct;
    assign o_result.overflow = r_out_overflow;
    assign o_result.slot     = r_out_slot;

`include "point_dedup_by_tolerance_macros.svh"

    `PDT_ASSERT_IMP(a_chk_behind_rd, 1'b1, r_chk_row <= r_rd_row, "checked rows ahead of reads")
    `PDT_ASSERT_IMP(a_lane_in_scan, w_vld[0], r_state == S_SCAN, "lane result outside a scan")
    `PDT_ASSERT_IMP(a_lanes_aligned, 1'b1, (&w_vld) == (|w_vld), "compare lanes out of step")
    `PDT_ASSERT_IMP(a_rose_from_done, $rose(r_out_valid), $past(r_state == S_DONE),
                    "result raised outside the decision state")
    `PDT_ASSERT_NXT(a_store_count, w_store, r_count == $past(n_count_p1),
                    "kept count did not advance on store")

endmodule

>>> rtl/pdt_ram.sv
module pdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pdt_lane.sv
// One compare lane: |d|, squares, sum against tolerance. Three register stages.
module pdt_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic                          i_en,
    input  pdt_pkg::t_point               i_pt,
    input  pdt_pkg::t_point               i_entry,
    input  logic [pdt_pkg::TOL_BITS-1:0]  i_tol,
    output logic                          o_vld,
    output logic                          o_hit
);

    logic                           r_vld1, r_vld2, r_vld3;
    logic                           r_en1, r_en2, r_hit3;
    logic [pdt_pkg::DIFF_BITS-1:0]  r_dx, r_dy, r_dz;
    logic [pdt_pkg::SQ_BITS-1:0]    r_sx, r_sy, r_sz;
    logic [pdt_pkg::SUM_BITS-1:0]   w_sum;

    assign w_sum = pdt_pkg::SUM_BITS'(r_sx) + pdt_pkg::SUM_BITS'(r_sy)
                 + pdt_pkg::SUM_BITS'(r_sz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_en1  <= 1'b0;
            r_en2  <= 1'b0;
            r_hit3 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_en1  <= i_vld && i_en;
            r_vld2 <= r_vld1;
            r_en2  <= r_en1;
            r_vld3 <= r_vld2;
            r_hit3 <= r_en2 && (w_sum < pdt_pkg::SUM_BITS'(i_tol));
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= pdt_pkg::abs_diff(i_pt.x, i_entry.x);
        r_dy <= pdt_pkg::abs_diff(i_pt.y, i_entry.y);
        r_dz <= pdt_pkg::abs_diff(i_pt.z, i_entry.z);
        r_sx <= pdt_pkg::SQ_BITS'(r_dx) * pdt_pkg::SQ_BITS'(r_dx);
        r_sy <= pdt_pkg::SQ_BITS'(r_dy) * pdt_pkg::SQ_BITS'(r_dy);
        r_sz <= pdt_pkg::SQ_BITS'(r_dz) * pdt_pkg::SQ_BITS'(r_dz);
    end

    assign o_vld = r_vld3;
    assign o_hit = r_hit3;

endmodule
